// ===== rtl/core/feedforward_pwm_interpolator_defines.svh =====
// Assertion macros for the feedforward interpolator checker.
// No dependencies; included by the checker file.
`ifndef FEEDFORWARD_PWM_INTERPOLATOR_DEFINES_SVH
`define FEEDFORWARD_PWM_INTERPOLATOR_DEFINES_SVH

// checked only while out of reset
`define FPI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("feedforward interpolator check failed");

// checked at every edge, reset included
`define FPI_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("feedforward interpolator check failed during reset");

`endif

// ===== rtl/core/fpi_pkg.sv =====
// Shared widths, register indexes and payload types for the feedforward interpolator.
// No dependencies; imported by fpi_div, feedforward_pwm_interpolator and fpi_checker.
`default_nettype none

package fpi_pkg;

    localparam int POINTS    = 4;
    localparam int REG_W     = 15;
    localparam int CFG_IDX_W = 3;
    localparam int TARGET_W  = 16;
    localparam int MAG_W     = 16;
    localparam int DRIVE_W   = 16;
    localparam int NUM_W     = 2 * REG_W;
    localparam int DIV_STEPS = REG_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_0 = 3'd0,
        REG_SPEED_1 = 3'd1,
        REG_SPEED_2 = 3'd2,
        REG_SPEED_3 = 3'd3,
        REG_DRIVE_0 = 3'd4,
        REG_DRIVE_1 = 3'd5,
        REG_DRIVE_2 = 3'd6,
        REG_DRIVE_3 = 3'd7
    } cfg_reg_t;

    // carried alongside the division
    typedef struct packed {
        logic [REG_W-1:0] base;
        logic             q_neg;
        logic             neg;
        logic             clamp;
    } fpi_side_t;

endpackage

`default_nettype wire

// ===== rtl/core/feedforward_pwm_interpolator.sv =====
// Feedforward interpolator: signed target speed to signed drive over a four-point table.
// Throughput: one request per cycle while the output is not stalled;
// depth is set by the 15-stage divider pipeline.
// A stalled output back-pressures stage by stage; empty stages keep filling.
// Reset (async, active low) empties the pipeline and clears the table to zero.
`default_nettype none

module feedforward_pwm_interpolator
    import fpi_pkg::*;
#(
    parameter bit FEEDFORWARD_ON = 1'b1
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [REG_W-1:0]           cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [TARGET_W-1:0] target_speed,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [DRIVE_W-1:0]       drive_value,
    output logic                            clamped
);

    logic [REG_W-1:0] speed_reg [POINTS];
    logic [REG_W-1:0] drive_reg [POINTS];

    // configuration table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POINTS; i++)
            begin
                speed_reg[i] <= '0;
                drive_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SPEED_0: speed_reg[0] <= cfg_data;
                REG_SPEED_1: speed_reg[1] <= cfg_data;
                REG_SPEED_2: speed_reg[2] <= cfg_data;
                REG_SPEED_3: speed_reg[3] <= cfg_data;
                REG_DRIVE_0: drive_reg[0] <= cfg_data;
                REG_DRIVE_1: drive_reg[1] <= cfg_data;
                REG_DRIVE_2: drive_reg[2] <= cfg_data;
                REG_DRIVE_3: drive_reg[3] <= cfg_data;
                default:     drive_reg[3] <= drive_reg[3];
            endcase
        end
    end

    // stage handshake
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;
    logic div_in_ready, div_out_valid;

    logic                       a_valid_reg;
    logic signed [TARGET_W-1:0] a_target_reg;

    logic             b_valid_reg;
    logic             b_neg_reg, b_le0_reg, b_ge3_reg, b_le1_reg, b_le2_reg, b_clamp_reg;
    logic [MAG_W-1:0] b_mag_reg;
    logic             b_neg_next;
    logic [MAG_W-1:0] b_mag_next;

    logic             c_valid_reg;
    fpi_side_t        c_side_reg, c_side_next;
    logic [REG_W-1:0] c_a_reg, c_span_reg, c_dd_reg;
    logic [REG_W-1:0] c_a_next, c_span_next, c_dd_next;

    logic             d_valid_reg;
    logic [NUM_W-1:0] d_num_reg;
    logic [REG_W-1:0] d_den_reg;
    fpi_side_t        d_side_reg;

    logic [REG_W-1:0] div_quot;
    fpi_side_t        div_side;

    logic                      e_valid_reg;
    logic signed [DRIVE_W-1:0] e_sum_reg, e_sum_next;
    logic                      e_neg_reg, e_clamp_reg;

    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_value_reg, drive_value_next;
    logic                      clamped_reg;

    assign rdy_f    = !out_valid_reg || !out_stall;
    assign rdy_e    = !e_valid_reg || rdy_f;
    assign rdy_d    = !d_valid_reg || div_in_ready;
    assign rdy_c    = !c_valid_reg || rdy_d;
    assign rdy_b    = !b_valid_reg || rdy_c;
    assign rdy_a    = !a_valid_reg || rdy_b;
    assign in_stall = !rdy_a;

    // sign and magnitude; the table compares are made on the magnitude in stage b
    always_comb
    begin
        b_neg_next = a_target_reg[TARGET_W-1];
        b_mag_next = b_neg_next ? MAG_W'(-a_target_reg) : MAG_W'(a_target_reg);
    end

    // segment select, offsets and slope
    always_comb
    begin
        logic [REG_W-1:0] lo, hi, d0, d1;
        logic [REG_W:0]   dd;
        logic [MAG_W-1:0] off;
        lo = speed_reg[2];
        hi = speed_reg[3];
        d0 = drive_reg[2];
        d1 = drive_reg[3];
        if (b_le1_reg)
        begin
            lo = speed_reg[0];
            hi = speed_reg[1];
            d0 = drive_reg[0];
            d1 = drive_reg[1];
        end
        else if (b_le2_reg)
        begin
            lo = speed_reg[1];
            hi = speed_reg[2];
            d0 = drive_reg[1];
            d1 = drive_reg[2];
        end
        off          = b_mag_reg - {1'b0, lo};
        dd           = {1'b0, d1} - {1'b0, d0};
        c_span_next  = hi - lo;
        c_a_next     = off[REG_W-1:0];
        c_dd_next    = dd[REG_W] ? REG_W'(-dd) : dd[REG_W-1:0];
        c_side_next.base  = d0;
        c_side_next.q_neg = dd[REG_W];
        c_side_next.neg   = b_neg_reg;
        c_side_next.clamp = b_clamp_reg;
        // end points and empty segments: end-point or left value, nothing to divide
        if (b_le0_reg || b_ge3_reg || c_span_next == '0)
        begin
            c_a_next    = '0;
            c_span_next = REG_W'(1);
            if (b_le0_reg)
                c_side_next.base = drive_reg[0];
            else if (b_ge3_reg)
                c_side_next.base = drive_reg[POINTS-1];
        end
    end

    always_comb
    begin
        e_sum_next = div_side.q_neg
                   ? DRIVE_W'({1'b0, div_side.base} - {1'b0, div_quot})
                   : DRIVE_W'({1'b0, div_side.base} + {1'b0, div_quot});
    end

    always_comb
    begin
        drive_value_next = e_neg_reg ? -e_sum_reg : e_sum_reg;
        if (!FEEDFORWARD_ON)
            drive_value_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                a_valid_reg <= in_valid;
            if (rdy_b)
                b_valid_reg <= a_valid_reg;
            if (rdy_c)
                c_valid_reg <= b_valid_reg;
            if (rdy_d)
                d_valid_reg <= c_valid_reg;
            if (rdy_e)
                e_valid_reg <= div_out_valid;
            if (rdy_f)
                out_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
            a_target_reg <= target_speed;
        if (rdy_b && a_valid_reg)
        begin
            b_neg_reg   <= b_neg_next;
            b_mag_reg   <= b_mag_next;
            b_le0_reg   <= b_mag_next <= {1'b0, speed_reg[0]};
            b_le1_reg   <= b_mag_next <= {1'b0, speed_reg[1]};
            b_le2_reg   <= b_mag_next <= {1'b0, speed_reg[2]};
            b_ge3_reg   <= b_mag_next >= {1'b0, speed_reg[POINTS-1]};
            b_clamp_reg <= (b_mag_next < {1'b0, speed_reg[0]})
                        || (b_mag_next > {1'b0, speed_reg[POINTS-1]});
        end
        if (rdy_c && b_valid_reg)
        begin
            c_side_reg <= c_side_next;
            c_a_reg    <= c_a_next;
            c_span_reg <= c_span_next;
            c_dd_reg   <= c_dd_next;
        end
        if (rdy_d && c_valid_reg)
        begin
            d_num_reg  <= NUM_W'(c_a_reg) * NUM_W'(c_dd_reg);
            d_den_reg  <= c_span_reg;
            d_side_reg <= c_side_reg;
        end
        if (rdy_e && div_out_valid)
        begin
            e_sum_reg   <= e_sum_next;
            e_neg_reg   <= div_side.neg;
            e_clamp_reg <= div_side.clamp;
        end
        if (rdy_f && e_valid_reg)
        begin
            drive_value_reg <= drive_value_next;
            clamped_reg     <= FEEDFORWARD_ON ? e_clamp_reg : 1'b0;
        end
    end

    fpi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid_reg),
        .in_ready  (div_in_ready),
        .num       (d_num_reg),
        .den       (d_den_reg),
        .in_side   (d_side_reg),
        .out_valid (div_out_valid),
        .out_ready (rdy_e),
        .quot      (div_quot),
        .out_side  (div_side)
    );

    assign out_valid   = out_valid_reg;
    assign drive_value = drive_value_reg;
    assign clamped     = clamped_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fpi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, side data alongside.
// Depends on fpi_pkg. Requires num < den * 2**REG_W.
`default_nettype none

module fpi_div
    import fpi_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [REG_W-1:0] den,
    input  wire fpi_side_t        in_side,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [REG_W-1:0]      quot,
    output fpi_side_t             out_side
);

    logic             valid_reg [DIV_STEPS];
    logic [REG_W-1:0] rem_reg   [DIV_STEPS];
    logic [REG_W-1:0] shq_reg   [DIV_STEPS];
    logic [REG_W-1:0] den_reg   [DIV_STEPS];
    fpi_side_t        side_reg  [DIV_STEPS];

    logic             src_valid [DIV_STEPS];
    logic [REG_W-1:0] src_rem   [DIV_STEPS];
    logic [REG_W-1:0] src_shq   [DIV_STEPS];
    logic [REG_W-1:0] src_den   [DIV_STEPS];
    fpi_side_t        src_side  [DIV_STEPS];

    logic             ready     [DIV_STEPS+1];

    assign ready[DIV_STEPS] = out_ready;
    assign in_ready         = ready[0];
    assign out_valid        = valid_reg[DIV_STEPS-1];
    assign quot             = shq_reg[DIV_STEPS-1];
    assign out_side         = side_reg[DIV_STEPS-1];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [REG_W:0]   trial;
        logic [REG_W+1:0] diff;
        logic [REG_W-1:0] rem_next;
        logic [REG_W-1:0] shq_next;

        if (k == 0) begin : g_first
            assign src_valid[k] = in_valid;
            assign src_rem[k]   = num[NUM_W-1:REG_W];
            assign src_shq[k]   = num[REG_W-1:0];
            assign src_den[k]   = den;
            assign src_side[k]  = in_side;
        end
        else begin : g_rest
            assign src_valid[k] = valid_reg[k-1];
            assign src_rem[k]   = rem_reg[k-1];
            assign src_shq[k]   = shq_reg[k-1];
            assign src_den[k]   = den_reg[k-1];
            assign src_side[k]  = side_reg[k-1];
        end

        assign ready[k] = !valid_reg[k] || ready[k+1];

        always_comb
        begin
            trial = {src_rem[k], src_shq[k][REG_W-1]};
            diff  = {1'b0, trial} - {2'b00, src_den[k]};
            if (!diff[REG_W+1])
            begin
                rem_next = diff[REG_W-1:0];
                shq_next = {src_shq[k][REG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[REG_W-1:0];
                shq_next = {src_shq[k][REG_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (ready[k])
                valid_reg[k] <= src_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (ready[k] && src_valid[k])
            begin
                rem_reg[k]  <= rem_next;
                shq_reg[k]  <= shq_next;
                den_reg[k]  <= src_den[k];
                side_reg[k] <= src_side[k];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fpi_checker.sv =====
// Port-level checks for the feedforward interpolator, bound to the top level.
// Depends on fpi_pkg and feedforward_pwm_interpolator_defines.svh.
`default_nettype none
`include "feedforward_pwm_interpolator_defines.svh"

module fpi_checker
    import fpi_pkg::*;
#(
    parameter bit FEEDFORWARD_ON = 1'b1
)
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic signed [DRIVE_W-1:0]  drive_value,
    input wire logic                       clamped
);

    `FPI_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !out_valid)

    `FPI_ASSERT(a_out_hold, clk, rst_n,
        out_valid && out_stall |=> out_valid && $stable(drive_value) && $stable(clamped))

    // request side only backs up once the whole pipe is full and stalled
    `FPI_ASSERT(a_stall_full, clk, rst_n, in_stall |-> out_valid && out_stall)

    `FPI_ASSERT(a_disabled_zero, clk, rst_n,
        out_valid && !FEEDFORWARD_ON |-> drive_value == '0 && !clamped)

endmodule

bind feedforward_pwm_interpolator fpi_checker #(
    .FEEDFORWARD_ON (FEEDFORWARD_ON)
) u_fpi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_value (drive_value),
    .clamped     (clamped)
);

`default_nettype wire
